FILE: rtl/wsr_pkg.sv
`default_nettype none
package wsr_pkg;

    localparam int MAX_TOKENS = 32;
    localparam logic [7:0] WILDCARD_BYTE = 8'd46;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_TEXT   = 2'd2,
        MODE_END    = 2'd3
    } t_mode;

    // broadcast from the top level to every cell, mode strobes already qualified by the accept
    typedef struct packed {
        logic       clear;
        logic       append;
        logic       text;
        logic       restart;
        logic [7:0] symbol;
        logic       repeat_req;
    } t_cmd;

    // handed from each cell to its right-hand neighbour
    typedef struct packed {
        logic head;
        logic used;
        logic skip;
        logic step;
    } t_link;

endpackage
`default_nettype wire

FILE: rtl/wsr_cell.sv
`default_nettype none
module wsr_cell
    import wsr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cmd  i_cmd,
    input  wire t_link i_link,
    output t_link      o_link,
    output logic       o_match
);

    logic       r_used;
    logic       r_act;
    logic [7:0] r_sym;
    logic       r_rep;

    logic       n_used;
    logic       n_act;
    logic       w_closed;
    logic       w_hit;
    logic       w_load;

    // closed activity of this position: own bit, or skipped in over a starred token
    assign w_closed = r_act | i_link.skip;
    assign w_hit    = r_used & w_closed & ((r_sym == WILDCARD_BYTE) || (r_sym == i_cmd.symbol));
    assign w_load   = i_cmd.append & ~r_used & i_link.used;

    assign o_link.head = 1'b0;
    assign o_link.used = r_used;
    assign o_link.skip = w_closed & r_used & r_rep;
    assign o_link.step = w_hit & ~r_rep;

    // this position is the end of the pattern when the left one is used and this is not
    assign o_match = w_closed & i_link.used & ~r_used;

    always_comb begin
        n_used = r_used;
        if (i_cmd.clear) begin
            n_used = 1'b0;
        end else if (w_load) begin
            n_used = 1'b1;
        end
    end

    always_comb begin
        n_act = r_act;
        if (i_cmd.restart) begin
            n_act = i_link.head;
        end else if (i_cmd.text) begin
            n_act = (w_hit & r_rep) | i_link.step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_act  <= i_link.head;
        end else begin
            r_used <= n_used;
            r_act  <= n_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_sym <= i_cmd.symbol;
            r_rep <= i_cmd.repeat_req;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/wildcard_star_regex_matcher.sv
`default_nettype none
// channel | direction | handshake          | payload
// input   | in        | i_valid / o_ready  | i_mode, i_symbol, i_repeat_req
// result  | out       | o_valid / i_ready  | o_matched, o_overflow
//
// one beat per cycle when not stalled, every mode; the whole position set of the
// cell row updates in the cycle the beat is taken, closure ripples along the row
// an end-of-text beat puts its result in the output register on the next edge
// reset leaves an empty pattern with only position zero active, no clearing pass
// a stalled result holds the output register and holds off every input beat
// until it is taken
module wildcard_star_regex_matcher
    import wsr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [1:0] i_mode,
    input  wire logic [7:0] i_symbol,
    input  wire logic       i_repeat_req,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_matched,
    output logic            o_overflow
);

    logic                  w_accept;
    t_mode                 w_mode;
    t_cmd                  w_cmd;
    t_link                 w_link [MAX_TOKENS+1];
    logic [MAX_TOKENS-1:0] w_match;
    logic [MAX_TOKENS-1:0] w_used;
    logic                  w_closed_end;
    logic                  w_matched;

    logic r_act_end;
    logic r_ovf;
    logic r_out_valid;
    logic r_matched;
    logic r_out_ovf;

    logic n_act_end;
    logic n_ovf;

    assign o_ready  = ~r_out_valid | i_ready;
    assign w_accept = i_valid & o_ready;
    assign w_mode   = t_mode'(i_mode);

    always_comb begin
        w_cmd.clear      = w_accept & (w_mode == MODE_CLEAR);
        w_cmd.append     = w_accept & (w_mode == MODE_APPEND);
        w_cmd.text       = w_accept & (w_mode == MODE_TEXT);
        w_cmd.restart    = w_accept & (w_mode != MODE_TEXT);
        w_cmd.symbol     = i_symbol;
        w_cmd.repeat_req = i_repeat_req;
    end

    assign w_link[0] = '{head: 1'b1, used: 1'b1, skip: 1'b0, step: 1'b0};

    for (genvar g = 0; g < MAX_TOKENS; g++) begin : g_cell
        wsr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1]),
            .o_match (w_match[g])
        );
        assign w_used[g] = w_link[g+1].used;
    end

    // position past the last cell is only the end when every cell is used
    assign w_closed_end = r_act_end | w_link[MAX_TOKENS].skip;
    assign w_matched    = (|w_match) | w_closed_end;

    always_comb begin
        n_act_end = r_act_end;
        if (w_cmd.restart) begin
            n_act_end = 1'b0;
        end else if (w_cmd.text) begin
            n_act_end = w_link[MAX_TOKENS].step;
        end
    end

    always_comb begin
        n_ovf = r_ovf;
        if (w_cmd.clear) begin
            n_ovf = 1'b0;
        end else if (w_cmd.append & w_link[MAX_TOKENS].used) begin
            n_ovf = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_end   <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_act_end <= n_act_end;
            r_ovf     <= n_ovf;
            if (w_accept && (w_mode == MODE_END)) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (w_mode == MODE_END)) begin
            r_matched <= w_matched;
            r_out_ovf <= r_ovf;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_matched  = r_matched;
    assign o_overflow = r_out_ovf;

    // a result only appears after an end-of-text beat
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_accept && (w_mode == MODE_END)))
        else $error("result without end-of-text beat");

    // used cells always fill from the left
    a_used_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_used + {{(MAX_TOKENS-1){1'b0}}, 1'b1}))
        else $error("used cells not contiguous");

    // overflow only once the row is full
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (&w_used))
        else $error("overflow with free cells");

    // a clear empties the row, drops overflow and deactivates the end position
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear |=> (!r_ovf && (w_used == '0) && !r_act_end))
        else $error("clear left state behind");

endmodule
`default_nettype wire
